FILE: src/rae_pkg.sv
// shared types, constants and helpers of the register alu executor
// no dependencies; imported by rae_alu, rae_regfile and the top level
package rae_pkg;

    localparam int NUM_REGS  = 5;
    localparam int WORD_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int CMD_W     = 4;
    localparam int RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DIV_CNT_W = $clog2(WORD_W);
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [CMD_W-1:0]     t_cmd;

    localparam t_cmd CMD_LOAD  = 4'd0;
    localparam t_cmd CMD_MOVR  = 4'd1;
    localparam t_cmd CMD_ADDR  = 4'd2;
    localparam t_cmd CMD_SUBR  = 4'd3;
    localparam t_cmd CMD_MULR  = 4'd4;
    localparam t_cmd CMD_MODR  = 4'd5;
    localparam t_cmd CMD_DIVR  = 4'd6;
    localparam t_cmd CMD_INCR  = 4'd7;
    localparam t_cmd CMD_DECR  = 4'd8;
    localparam t_cmd CMD_COMP  = 4'd9;
    localparam t_cmd CMD_CGEQ  = 4'd10;
    localparam t_cmd CMD_CLEQ  = 4'd11;
    localparam t_cmd CMD_SHIF  = 4'd12;
    localparam t_cmd CMD_GOTO  = 4'd13;
    localparam t_cmd CMD_JUMP  = 4'd14;

    typedef struct packed {
        logic  start;
        t_cmd  cmd;
        t_word x;
        t_word y;
        t_word imm;
    } t_alu_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        logic  div_zero;
        t_word value;
    } t_alu_rsp;

    typedef struct packed {
        logic     en;
        t_reg_idx addr;
        t_word    data;
    } t_rf_wr;

    function automatic logic rf_in_range(input t_reg_idx idx);
        return int'(idx) < NUM_REGS;
    endfunction

endpackage

FILE: src/register_alu_executor_core.sv
// top level of the register alu executor: sequencer, pc, error flag, output register
// depends on rae_pkg, rae_regfile and rae_alu
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------
//  s (instr) | in        | i_s_tvalid / o_s_tready    | i_s_tdata: cmd, regs, imm, jnz
//  m (result)| out       | o_m_tvalid / i_m_tready    | o_m_tdata: dest, value, pc, err
//  cfg       | in        | i_cfg_we (no wait)         | i_cfg_wdata: code_base
//
// one instruction at a time: o_s_tready is high only while the sequencer is idle
// simple ops go from accept to result through the alu's registered path; div and mod also
// run the shared restoring divider with its operand and sign-fix steps
// synchronous active-low reset clears registers a..e (via valid bits), pc and error
// a stalled result sits in the output register; the next instruction is accepted
// meanwhile and waits at its commit step until that register frees up
module register_alu_executor_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // fields from bit 0: cmd[3:0], first_register[6:4], second_register[9:7],
    // immediate[41:10], jump_if_nonzero[42], zero pad
    input  logic [rae_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // fields from bit 0: dest_index[2:0], dest_written[3], dest_value[35:4],
    // program_counter[67:36], zero_div_error[68], zero pad
    output logic [rae_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_cfg_we,
    input  rae_pkg::t_word                    i_cfg_wdata
);
    import rae_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
    localparam logic [1:0] S_EXEC = 2'd1;  // operands ready, kick the alu
    localparam logic [1:0] S_WAIT = 2'd2;  // alu working
    localparam logic [1:0] S_FIN  = 2'd3;  // commit once the output register is free

    logic [1:0] r_state;
    logic [1:0] n_state;

    // captured instruction
    t_cmd     r_cmd;
    t_reg_idx r_r1;
    t_word    r_imm;
    logic     r_jnz;

    // architectural state outside the register file
    t_word r_pc;
    logic  r_err;
    t_word r_code_base;

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // input field split
    t_cmd     in_cmd;
    t_reg_idx in_r1;
    t_reg_idx in_r2;
    t_word    in_imm;
    logic     in_jnz;

    logic     s_accept;
    logic     commit;
    t_word    rd0_data;
    t_word    rd1_data;
    t_reg_idx rd0_addr;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_rf_wr   rf_wr;

    // commit decode
    logic     is_div;
    logic     dz_hit;
    logic     writes_reg;
    t_reg_idx dest;
    logic     wr_ok;
    t_word    n_pc;
    logic     n_err;

    assign in_cmd = i_s_tdata[3:0];
    assign in_r1  = i_s_tdata[6:4];
    assign in_r2  = i_s_tdata[9:7];
    assign in_imm = i_s_tdata[41:10];
    assign in_jnz = i_s_tdata[42];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // jumps test register a, which is the only operand they need
    assign rd0_addr = (in_cmd == CMD_JUMP) ? '0 : in_r1;

    rae_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_accept),
        .i_rd0_addr (rd0_addr),
        .i_rd1_addr (in_r2),
        .i_wr       (rf_wr),
        .o_rd0_data (rd0_data),
        .o_rd1_data (rd1_data)
    );

    always_comb begin
        alu_req.start = (r_state == S_EXEC);
        alu_req.cmd   = r_cmd;
        alu_req.x     = rd0_data;
        alu_req.y     = rd1_data;
        alu_req.imm   = r_imm;
    end

    rae_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_WAIT;
            S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign commit = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    // result decode
    always_comb begin
        is_div     = (r_cmd == CMD_DIVR) || (r_cmd == CMD_MODR);
        dz_hit     = is_div && alu_rsp.div_zero;
        writes_reg = (r_cmd <= CMD_SHIF) && !dz_hit;
        case (r_cmd)
            CMD_LOAD, CMD_MOVR, CMD_INCR, CMD_DECR, CMD_SHIF: dest = r_r1;
            default: dest = '0;
        endcase
        // writes beyond the last register are dropped and reported as no write
        wr_ok = writes_reg && rf_in_range(dest);
        n_err = r_err | dz_hit;
        case (r_cmd)
            CMD_GOTO: n_pc = r_code_base + rd0_data;
            CMD_JUMP: n_pc = ((rd0_data != '0) == r_jnz) ? r_imm : r_pc;
            default:  n_pc = r_pc;
        endcase
    end

    always_comb begin
        rf_wr.en   = commit && wr_ok;
        rf_wr.addr = dest;
        rf_wr.data = alu_rsp.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_err       <= 1'b0;
            r_code_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_code_base <= i_cfg_wdata;
            end
            if (commit) begin
                r_pc        <= n_pc;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // instruction capture and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= in_cmd;
            r_r1  <= in_r1;
            r_imm <= in_imm;
            r_jnz <= in_jnz;
        end
        if (commit) begin
            r_out_data <= {3'b000, n_err, n_pc,
                           wr_ok ? alu_rsp.value : t_word'(0),
                           wr_ok,
                           wr_ok ? dest : t_reg_idx'(0)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // the input side is closed whenever the shared unit is still working
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !alu_rsp.busy)
        else $error("instruction port open while the alu is busy");

    // a new result only ever appears through the commit step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the commit step");

    // the divide-by-zero flag is sticky until reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    // a result without a register write carries zero index and value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[3]) |-> (o_m_tdata[2:0] == '0 && o_m_tdata[35:4] == '0))
        else $error("non-writing result carries a destination");

endmodule

FILE: src/rae_regfile.sv
// register file a..e with two registered read ports and one write port
// depends on rae_pkg; entries read as zero until written or when out of range
module rae_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  rae_pkg::t_reg_idx i_rd0_addr,
    input  rae_pkg::t_reg_idx i_rd1_addr,
    input  rae_pkg::t_rf_wr   i_wr,
    output rae_pkg::t_word    o_rd0_data,
    output rae_pkg::t_word    o_rd1_data
);
    import rae_pkg::*;

    t_word                mem [NUM_REGS];
    logic  [NUM_REGS-1:0] r_valid;
    t_word                r_rd0;
    t_word                r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && rf_in_range(i_wr.addr)) begin
            mem[i_wr.addr[RF_AW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en && rf_in_range(i_wr.addr)) begin
            r_valid[i_wr.addr[RF_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= (rf_in_range(i_rd0_addr) && r_valid[i_rd0_addr[RF_AW-1:0]])
                     ? mem[i_rd0_addr[RF_AW-1:0]] : '0;
            r_rd1 <= (rf_in_range(i_rd1_addr) && r_valid[i_rd1_addr[RF_AW-1:0]])
                     ? mem[i_rd1_addr[RF_AW-1:0]] : '0;
        end
    end

    assign o_rd0_data = r_rd0;
    assign o_rd1_data = r_rd1;

endmodule

FILE: src/rae_alu.sv
// shared arithmetic unit: registered simple ops plus a radix-2 restoring divider
// depends on rae_pkg; driven by the sequencer in the top level
module rae_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rae_pkg::t_alu_req i_req,
    output rae_pkg::t_alu_rsp o_rsp
);
    import rae_pkg::*;

    localparam logic [1:0] ALU_IDLE = 2'd0;
    localparam logic [1:0] ALU_DIV  = 2'd1;
    localparam logic [1:0] ALU_FIX  = 2'd2;

    logic [1:0]           r_state;
    logic                 r_done;
    logic                 r_dz;
    t_word                r_value;
    t_word                r_rem;
    t_word                r_quo;
    t_word                r_div;
    logic                 r_neg_a;
    logic                 r_neg_q;
    logic                 r_is_mod;
    logic [DIV_CNT_W-1:0] r_cnt;

    t_word        simple_val;
    t_word        shift_val;
    t_word        neg_imm;
    t_word        abs_x;
    t_word        abs_y;
    t_word        rem_shift;
    logic [WORD_W:0] trial;
    logic         is_div;

    // shift by immediate: positive is arithmetic right, negative is left
    always_comb begin
        neg_imm = '0 - i_req.imm;
        if (!i_req.imm[WORD_W-1]) begin
            if (|i_req.imm[WORD_W-2:5]) begin
                shift_val = {WORD_W{i_req.x[WORD_W-1]}};
            end else begin
                shift_val = t_word'($signed(i_req.x) >>> i_req.imm[4:0]);
            end
        end else begin
            if (|neg_imm[WORD_W-1:5]) begin
                shift_val = '0;
            end else begin
                shift_val = i_req.x << neg_imm[4:0];
            end
        end
    end

    always_comb begin
        case (i_req.cmd)
            CMD_LOAD: simple_val = i_req.imm;
            CMD_MOVR: simple_val = i_req.y;
            CMD_ADDR: simple_val = i_req.x + i_req.y;
            CMD_SUBR: simple_val = i_req.x - i_req.y;
            CMD_MULR: simple_val = i_req.x * i_req.y;
            CMD_INCR: simple_val = i_req.x + 1'b1;
            CMD_DECR: simple_val = i_req.x - 1'b1;
            CMD_COMP: simple_val = t_word'(i_req.x == i_req.y);
            CMD_CGEQ: simple_val = t_word'(!($signed(i_req.x) < $signed(i_req.y)));
            CMD_CLEQ: simple_val = t_word'(!($signed(i_req.y) < $signed(i_req.x)));
            CMD_SHIF: simple_val = shift_val;
            default:  simple_val = '0;
        endcase
    end

    always_comb begin
        is_div    = (i_req.cmd == CMD_DIVR) || (i_req.cmd == CMD_MODR);
        abs_x     = i_req.x[WORD_W-1] ? ('0 - i_req.x) : i_req.x;
        abs_y     = i_req.y[WORD_W-1] ? ('0 - i_req.y) : i_req.y;
        // partial remainder stays below the divisor, so the shift fits a word
        rem_shift = {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
        trial     = {1'b0, rem_shift} - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ALU_IDLE: begin
                    if (i_req.start) begin
                        if (is_div && (i_req.y != '0)) begin
                            r_state <= ALU_DIV;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ALU_DIV: begin
                    if (r_cnt == DIV_CNT_W'(WORD_W-1)) begin
                        r_state <= ALU_FIX;
                    end
                end
                ALU_FIX: begin
                    r_state <= ALU_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= ALU_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    r_dz     <= is_div && (i_req.y == '0);
                    r_value  <= simple_val;
                    r_rem    <= '0;
                    r_quo    <= abs_x;
                    r_div    <= abs_y;
                    r_neg_a  <= i_req.x[WORD_W-1];
                    r_neg_q  <= i_req.x[WORD_W-1] ^ i_req.y[WORD_W-1];
                    r_is_mod <= (i_req.cmd == CMD_MODR);
                    r_cnt    <= '0;
                end
            end
            ALU_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (!trial[WORD_W]) begin
                    r_rem <= trial[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift;
                    r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                end
            end
            ALU_FIX: begin
                if (r_is_mod) begin
                    r_value <= r_neg_a ? ('0 - r_rem) : r_rem;
                end else begin
                    r_value <= r_neg_q ? ('0 - r_quo) : r_quo;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.busy     = (r_state != ALU_IDLE);
    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_rsp.value    = r_value;

endmodule

FILE: sim/register_alu_checker.sv
// result checker for the register alu executor: predicts each instruction and compares results
// depends on rae_pkg for widths and command codes; instantiated by tb_register_alu_executor_core
module register_alu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // fields from bit 0: cmd, first_register, second_register, immediate, jump_if_nonzero
    input  logic [rae_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // fields from bit 0: dest_index, dest_written, dest_value, program_counter, zero_div_error
    input  logic [rae_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_we,
    input  rae_pkg::t_word                i_cfg_wdata,
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rae_pkg::*;

    localparam t_reg_idx ACCUM_IDX = 3'd0;

    typedef struct packed {
        t_reg_idx dest_index;
        logic     dest_written;
        t_word    dest_value;
        t_word    program_counter;
        logic     zero_div_error;
    } t_result;

    t_word   regs [NUM_REGS];
    t_word   pc_q;
    t_word   code_base_q;
    logic    err_q;
    t_result pending_results [$];
    int      mismatch_count = 0;
    int      result_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_count, msg);
        mismatch_count++;
    endtask

    function automatic t_word read_reg(input t_reg_idx idx);
        if (int'(idx) < NUM_REGS)
            return regs[idx];
        return '0;
    endfunction

    // positive amount shifts right arithmetically, negative shifts left
    function automatic t_word shift_word(input t_word v, input t_word amt);
        t_word n;
        if (!amt[WORD_W-1]) begin
            if (amt == 0)
                return v;
            if (amt >= WORD_W)
                return {WORD_W{v[WORD_W-1]}};
            return t_word'($signed(v) >>> amt);
        end
        n = -amt;
        if (n >= WORD_W)
            return '0;
        return v << n;
    endfunction

    // truncating signed division on magnitudes, so min / -1 wraps cleanly
    function automatic t_word div_word(input t_word a, input t_word b, input logic want_rem);
        t_word ua;
        t_word ub;
        t_word uq;
        t_word ur;
        ua = a[WORD_W-1] ? -a : a;
        ub = b[WORD_W-1] ? -b : b;
        uq = ua / ub;
        ur = ua % ub;
        if (want_rem)
            return a[WORD_W-1] ? -ur : ur;
        return (a[WORD_W-1] ^ b[WORD_W-1]) ? -uq : uq;
    endfunction

    task automatic run_instruction(input logic [S_TDATA_W-1:0] d, output t_result res);
        t_cmd     cmd;
        t_reg_idx r1;
        t_reg_idx r2;
        t_word    imm;
        logic     jnz;
        t_word    x;
        t_word    y;
        logic     wr;
        t_reg_idx didx;
        t_word    val;
        cmd  = d[3:0];
        r1   = d[6:4];
        r2   = d[9:7];
        imm  = d[41:10];
        jnz  = d[42];
        x    = read_reg(r1);
        y    = read_reg(r2);
        wr   = 1'b0;
        didx = ACCUM_IDX;
        val  = '0;
        case (cmd)
            CMD_LOAD: begin wr = 1'b1; didx = r1; val = imm; end
            CMD_MOVR: begin wr = 1'b1; didx = r1; val = y; end
            CMD_ADDR: begin wr = 1'b1; val = x + y; end
            CMD_SUBR: begin wr = 1'b1; val = x - y; end
            CMD_MULR: begin wr = 1'b1; val = x * y; end
            CMD_MODR, CMD_DIVR: begin
                if (y == 0) begin
                    err_q = 1'b1;
                end else begin
                    wr  = 1'b1;
                    val = div_word(x, y, cmd == CMD_MODR);
                end
            end
            CMD_INCR: begin wr = 1'b1; didx = r1; val = x + 1; end
            CMD_DECR: begin wr = 1'b1; didx = r1; val = x - 1; end
            CMD_COMP: begin wr = 1'b1; val = t_word'(x == y); end
            CMD_CGEQ: begin wr = 1'b1; val = t_word'($signed(x) >= $signed(y)); end
            CMD_CLEQ: begin wr = 1'b1; val = t_word'($signed(x) <= $signed(y)); end
            CMD_SHIF: begin wr = 1'b1; didx = r1; val = shift_word(x, imm); end
            CMD_GOTO: pc_q = code_base_q + x;
            CMD_JUMP: begin
                if ((regs[ACCUM_IDX] != 0) == jnz)
                    pc_q = imm;
            end
            default: ;
        endcase
        // writes to a register beyond the file are dropped and reported as no write
        if (wr && int'(didx) >= NUM_REGS)
            wr = 1'b0;
        if (wr) begin
            regs[didx] = val;
        end else begin
            didx = ACCUM_IDX;
            val  = '0;
        end
        res.dest_index      = didx;
        res.dest_written    = wr;
        res.dest_value      = val;
        res.program_counter = pc_q;
        res.zero_div_error  = err_q;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (regs[i])
                regs[i] = '0;
            pc_q        = '0;
            code_base_q = '0;
            err_q       = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                code_base_q = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                got.dest_index      = i_m_tdata[2:0];
                got.dest_written    = i_m_tdata[3];
                got.dest_value      = i_m_tdata[35:4];
                got.program_counter = i_m_tdata[67:36];
                got.zero_div_error  = i_m_tdata[68];
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end else begin
                    want = pending_results.pop_front();
                    if (got.dest_index !== want.dest_index)
                        report_mismatch($sformatf("dest_index %0d, expected %0d",
                            got.dest_index, want.dest_index));
                    if (got.dest_written !== want.dest_written)
                        report_mismatch($sformatf("dest_written %b, expected %b",
                            got.dest_written, want.dest_written));
                    if (got.dest_value !== want.dest_value)
                        report_mismatch($sformatf("dest_value %h, expected %h",
                            got.dest_value, want.dest_value));
                    if (got.program_counter !== want.program_counter)
                        report_mismatch($sformatf("program_counter %h, expected %h",
                            got.program_counter, want.program_counter));
                    if (got.zero_div_error !== want.zero_div_error)
                        report_mismatch($sformatf("zero_div_error %b, expected %b",
                            got.zero_div_error, want.zero_div_error));
                end
                result_count++;
            end
            if (i_s_tvalid && i_s_tready) begin
                run_instruction(i_s_tdata, want);
                pending_results.push_back(want);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

FILE: sim/tb_register_alu_executor_core.sv
// testbench top for register_alu_executor_core: clock, reset, instruction stimulus and verdict
// depends on rae_pkg, the core under test and register_alu_checker
module tb_register_alu_executor_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rae_pkg::*;

    // command 15 has no name in the package; the core treats it as a no-op
    localparam t_cmd CMD_NOP = 4'd15;

    localparam t_reg_idx REG_A    = 3'd0;
    localparam t_reg_idx REG_B    = 3'd1;
    localparam t_reg_idx REG_C    = 3'd2;
    localparam t_reg_idx REG_D    = 3'd3;
    localparam t_reg_idx REG_E    = 3'd4;
    localparam t_reg_idx REG_BAD5 = 3'd5;
    localparam t_reg_idx REG_BAD6 = 3'd6;

    localparam logic JUMP_IF_ZERO    = 1'b0;
    localparam logic JUMP_IF_NONZERO = 1'b1;

    localparam t_word MIN_WORD = 32'h8000_0000;
    localparam t_word MAX_WORD = 32'h7FFF_FFFF;
    localparam t_word ALL_ONES = 32'hFFFF_FFFF;

    // about 2000 instructions with their idle gaps and stalls run well inside the limit,
    // which leaves a wide margin
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_COUNT  = 5;
    localparam int PHASE_ITEMS  = 370;
    // the settle time outlasts a divide or modulo, so it covers any late stray result
    localparam int SETTLE_CYCLES = 40;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    t_word                cfg_wdata = '0;

    logic  quiet      = 1'b0;   // no idling on either side in the final phase
    int    stall_left = 0;
    int    cycles     = 0;
    int    pending;
    int    fail_count;
    t_word bases [PHASE_COUNT];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    register_alu_executor_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    register_alu_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // result side back-pressure: random stall bursts
    always @(posedge clk) begin
        logic ready_next;
        if (quiet || !rst_n) begin
            ready_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            ready_next = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    // watchdog on the whole run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one instruction transaction, with an occasional idle burst in front of it
    task automatic send_instr(input t_cmd cmd, input t_reg_idx r1, input t_reg_idx r2,
                              input t_word imm, input logic jnz);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tdata  <= {5'b0, jnz, imm, r2, r1, cmd};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off until every outstanding instruction has produced its result;
    // the pending count is registered, hence the check after each edge
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // code_base only changes while the core is idle
    task automatic set_code_base(input t_word base);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // operand values leaning on small numbers and the signed extremes
    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 8) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: return MIN_WORD;
                    1: return MAX_WORD;
                    2: return ALL_ONES;
                    default: return '0;
                endcase
            end
            2: return $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    // shift amounts: mostly around the +-32 boundary, sometimes anything
    function automatic t_word rand_shift();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return MIN_WORD;
                    1: return MAX_WORD;
                    2: return 32'd32;
                    default: return -32'd32;
                endcase
            end
            default: return $urandom_range(0, 80) - 40;
        endcase
    endfunction

    // mostly real registers, now and then an index past the file
    function automatic t_reg_idx rand_reg();
        if ($urandom_range(0, 9) != 0)
            return t_reg_idx'($urandom_range(REG_A, REG_E));
        return t_reg_idx'($urandom_range(REG_BAD5, 7));
    endfunction

    // loads are weighted up so the registers keep changing; divide and modulo
    // get a good share as the longest path through the core
    function automatic t_cmd rand_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return CMD_LOAD;
        if (pick < 30) return CMD_MOVR;
        if (pick < 36) return CMD_ADDR;
        if (pick < 41) return CMD_SUBR;
        if (pick < 46) return CMD_MULR;
        if (pick < 54) return CMD_MODR;
        if (pick < 62) return CMD_DIVR;
        if (pick < 66) return CMD_INCR;
        if (pick < 70) return CMD_DECR;
        if (pick < 74) return CMD_COMP;
        if (pick < 78) return CMD_CGEQ;
        if (pick < 82) return CMD_CLEQ;
        if (pick < 90) return CMD_SHIF;
        if (pick < 94) return CMD_GOTO;
        if (pick < 99) return CMD_JUMP;
        return CMD_NOP;
    endfunction

    initial begin
        t_cmd cmd;
        bases = '{$urandom(), MIN_WORD, MAX_WORD, 32'h0000_0001, 32'h0000_0000};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, with the base at all ones so that goto wraps
        set_code_base(ALL_ONES);
        send_instr(CMD_LOAD, REG_A, REG_A, MIN_WORD, JUMP_IF_ZERO);
        send_instr(CMD_LOAD, REG_B, REG_A, ALL_ONES, JUMP_IF_ZERO);
        // most negative over minus one: quotient wraps, remainder zero
        send_instr(CMD_DIVR, REG_A, REG_B, '0, JUMP_IF_ZERO);
        send_instr(CMD_MODR, REG_A, REG_B, '0, JUMP_IF_ZERO);
        // remainder follows the dividend's sign
        send_instr(CMD_LOAD, REG_A, REG_A, -32'd7, JUMP_IF_ZERO);
        send_instr(CMD_LOAD, REG_C, REG_A, 32'd2, JUMP_IF_ZERO);
        send_instr(CMD_MODR, REG_A, REG_C, '0, JUMP_IF_ZERO);
        // increment and decrement across the signed wrap
        send_instr(CMD_LOAD, REG_D, REG_A, MAX_WORD, JUMP_IF_ZERO);
        send_instr(CMD_INCR, REG_D, REG_A, '0, JUMP_IF_ZERO);
        send_instr(CMD_DECR, REG_D, REG_A, '0, JUMP_IF_ZERO);
        send_instr(CMD_ADDR, REG_D, REG_B, '0, JUMP_IF_ZERO);
        send_instr(CMD_MULR, REG_D, REG_D, '0, JUMP_IF_ZERO);
        send_instr(CMD_CGEQ, REG_B, REG_D, '0, JUMP_IF_ZERO);
        send_instr(CMD_CLEQ, REG_B, REG_D, '0, JUMP_IF_ZERO);
        // destination beyond the register file: no write reported
        send_instr(CMD_MOVR, REG_BAD5, REG_D, '0, JUMP_IF_ZERO);
        // shifts: zero amount, 32 or more either way
        send_instr(CMD_SHIF, REG_B, REG_A, '0, JUMP_IF_ZERO);
        send_instr(CMD_SHIF, REG_D, REG_A, 32'd33, JUMP_IF_ZERO);
        send_instr(CMD_SHIF, REG_B, REG_A, 32'd33, JUMP_IF_ZERO);
        send_instr(CMD_SHIF, REG_B, REG_A, -32'd32, JUMP_IF_ZERO);
        // goto wraps around the top of the address space
        send_instr(CMD_GOTO, REG_C, REG_A, '0, JUMP_IF_ZERO);
        // a holds one here, so the nonzero jump is taken
        send_instr(CMD_JUMP, REG_A, REG_A, 32'hFFFF_FFFC, JUMP_IF_NONZERO);
        send_instr(CMD_NOP, REG_A, REG_A, ALL_ONES, JUMP_IF_NONZERO);
        send_instr(CMD_LOAD, REG_A, REG_A, '0, JUMP_IF_ZERO);
        send_instr(CMD_JUMP, REG_A, REG_A, MIN_WORD, JUMP_IF_ZERO);
        // zero divisors, one of them read from a register past the file;
        // the error flag stays set from here on
        send_instr(CMD_DIVR, REG_A, REG_E, '0, JUMP_IF_ZERO);
        send_instr(CMD_MODR, REG_B, REG_BAD6, '0, JUMP_IF_ZERO);

        // random part in phases, each under its own code base
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_code_base(bases[p]);
            if (p == PHASE_COUNT - 1)
                quiet <= 1'b1;
            repeat (PHASE_ITEMS) begin
                cmd = rand_cmd();
                send_instr(cmd, rand_reg(), rand_reg(),
                           (cmd == CMD_SHIF) ? rand_shift() : rand_word(),
                           logic'($urandom_range(0, 1)));
                if ($urandom_range(0, 299) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
